// ----- rtl/core/dch_pkg.sv -----
package dch_pkg;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} vtx_t;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	localparam logic [1:0] SIDE_ABOVE = 2'd0;
	localparam logic [1:0] SIDE_UNDER = 2'd1;
	localparam logic [1:0] SIDE_ON    = 2'd2;

	typedef enum logic [1:0] {
		OP_PLAN,
		OP_QUERY,
		OP_APPLY
	} store_op_t;

	typedef struct packed {
		logic      start;
		store_op_t op;
	} store_ctl_t;

	typedef struct packed {
		logic       busy;
		logic [1:0] side;
		logic       add;
	} store_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_UNDER,
		ST_U1_WAIT,
		ST_U2_WAIT,
		ST_RESOLVE,
		ST_J_RD,
		ST_J_LD,
		ST_J_WAIT,
		ST_K_INIT,
		ST_K_RD,
		ST_K_LD,
		ST_K_WAIT,
		ST_PLAN_END,
		ST_MV_INIT,
		ST_MV_RD,
		ST_MV_WR,
		ST_PUT,
		ST_DONE
	} store_st_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_RUN,
		T_APPLY,
		T_OUT
	} top_st_t;

	// x first, then y
	function automatic logic vless(input vtx_t a, input vtx_t b);
		logic r;
		if (a.x != b.x) r = $signed(a.x) < $signed(b.x);
		else r = $signed(a.y) < $signed(b.y);
		return r;
	endfunction

endpackage

// ----- rtl/core/dch_turn.sv -----
module dch_turn import dch_pkg::*; (
	input  logic clk,
	input  vtx_t tp,
	input  vtx_t tq,
	input  vtx_t tr,
	output logic lt
);

	logic signed [32:0] a_s1, b_s1, c_s1, d_s1;
	logic signed [65:0] ad_s2, bc_s2;

	// Strict left turn tp -> tq -> tr, taken from the operands through the s1 and s2 registers.
	always_ff @(posedge clk) begin
		a_s1  <= {tq.x[31], tq.x} - {tp.x[31], tp.x};
		b_s1  <= {tq.y[31], tq.y} - {tp.y[31], tp.y};
		c_s1  <= {tr.x[31], tr.x} - {tq.x[31], tq.x};
		d_s1  <= {tr.y[31], tr.y} - {tq.y[31], tq.y};
		ad_s2 <= a_s1 * d_s1;
		bc_s2 <= b_s1 * c_s1;
	end

	assign lt = ad_s2 > bc_s2;

endmodule

// ----- rtl/core/dch_store.sv -----
module dch_store import dch_pkg::*; #(
	parameter int HULL_DEPTH = 256,
	localparam int AW = $clog2(HULL_DEPTH),
	localparam int CW = $clog2(HULL_DEPTH + 2)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  store_ctl_t    ctl,
	input  vtx_t          pt,
	output store_sts_t    sts,
	output logic [CW-1:0] count,
	output logic [CW-1:0] newn
);

	vtx_t mem [HULL_DEPTH];
	vtx_t rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic          we;
	vtx_t          wdata;

	store_st_t state_q, state_d;
	store_op_t op_q;
	vtx_t p_q, cur_q, prev_q, nxt_q, tp_q, tq_q, tr_q;
	logic [CW-1:0] n_q, newn_q, idx_q, i_q, j_q, pre_q, src_q, dst_q, rem_q;
	logic [1:0] side_q, wt_q;
	logic add_q, asc_q, lt;

	dch_turn u_turn (.clk(clk), .tp(tp_q), .tq(tq_q), .tr(tr_q), .lt(lt));

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (ctl.start) begin
				if (ctl.op == OP_APPLY) state_d = add_q ? ST_MV_INIT : ST_DONE;
				else state_d = ST_SCAN;
			end
			ST_SCAN:     state_d = (idx_q < n_q) ? ST_SCAN_CHK : ST_UNDER;
			ST_SCAN_CHK: state_d = vless(rdata_q, p_q) ? ST_SCAN : ST_UNDER;
			ST_UNDER:    state_d = (idx_q >= n_q || idx_q == '0) ? ST_RESOLVE : ST_U1_WAIT;
			ST_U1_WAIT:  if (wt_q == '0) state_d = lt ? ST_RESOLVE : ST_U2_WAIT;
			ST_U2_WAIT:  if (wt_q == '0) state_d = ST_RESOLVE;
			ST_RESOLVE:  state_d = (op_q == OP_QUERY || side_q != SIDE_ABOVE) ? ST_DONE : ST_J_RD;
			ST_J_RD:     state_d = (j_q + CW'(1) < n_q) ? ST_J_LD : ST_K_INIT;
			ST_J_LD:     state_d = ST_J_WAIT;
			ST_J_WAIT:   if (wt_q == '0) state_d = lt ? ST_K_INIT : ST_J_RD;
			ST_K_INIT:   state_d = (i_q == '0) ? ST_PLAN_END : ST_K_RD;
			ST_K_RD:     state_d = (idx_q != '0) ? ST_K_LD : ST_PLAN_END;
			ST_K_LD:     state_d = ST_K_WAIT;
			ST_K_WAIT:   if (wt_q == '0) state_d = lt ? ST_PLAN_END : ST_K_RD;
			ST_PLAN_END: state_d = ST_DONE;
			ST_MV_INIT:  state_d = ST_MV_RD;
			ST_MV_RD:    state_d = (rem_q != '0) ? ST_MV_WR : ST_PUT;
			ST_MV_WR:    state_d = ST_MV_RD;
			ST_PUT:      state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory ports and status
	always_comb begin
		raddr = idx_q[AW-1:0];
		we    = 1'b0;
		waddr = pre_q[AW-1:0];
		wdata = p_q;
		unique case (state_q)
			ST_J_RD:  raddr = AW'(j_q + CW'(1));
			ST_K_RD:  raddr = AW'(idx_q - CW'(1));
			ST_MV_RD: raddr = src_q[AW-1:0];
			ST_MV_WR: begin
				we    = 1'b1;
				waddr = dst_q[AW-1:0];
				wdata = rdata_q;
			end
			ST_PUT:   we = 1'b1;
			default:  raddr = idx_q[AW-1:0];
		endcase
	end

	assign sts.busy = state_q != ST_IDLE;
	assign sts.side = side_q;
	assign sts.add  = add_q;
	assign count    = n_q;
	assign newn     = newn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			add_q   <= 1'b0;
			wt_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: if (ctl.start) begin
					op_q <= ctl.op;
					if (ctl.op != OP_APPLY) begin
						p_q    <= pt;
						idx_q  <= '0;
						add_q  <= 1'b0;
						newn_q <= n_q;
						side_q <= SIDE_ABOVE;
					end
				end
				ST_SCAN_CHK: begin
					if (vless(rdata_q, p_q)) begin
						prev_q <= rdata_q;
						idx_q  <= idx_q + CW'(1);
					end else begin
						cur_q <= rdata_q;
					end
				end
				ST_UNDER: begin
					i_q <= idx_q;
					if (idx_q >= n_q) side_q <= SIDE_ABOVE;
					else if (idx_q == '0) side_q <= (cur_q == p_q) ? SIDE_ON : SIDE_ABOVE;
					else begin
						tp_q <= p_q; tq_q <= cur_q; tr_q <= prev_q; wt_q <= 2'd2;
					end
				end
				ST_U1_WAIT: begin
					if (wt_q != '0) wt_q <= wt_q - 2'd1;
					else if (lt) side_q <= SIDE_UNDER;
					else begin
						tp_q <= p_q; tq_q <= prev_q; tr_q <= cur_q; wt_q <= 2'd2;
					end
				end
				ST_U2_WAIT: begin
					if (wt_q != '0) wt_q <= wt_q - 2'd1;
					else side_q <= lt ? SIDE_ABOVE : SIDE_ON;
				end
				ST_RESOLVE: j_q <= i_q;
				ST_J_LD: begin
					nxt_q <= rdata_q;
					tp_q <= rdata_q; tq_q <= cur_q; tr_q <= p_q; wt_q <= 2'd2;
				end
				ST_J_WAIT: begin
					if (wt_q != '0) wt_q <= wt_q - 2'd1;
					else if (!lt) begin
						cur_q <= nxt_q;
						j_q   <= j_q + CW'(1);
					end
				end
				ST_K_INIT: begin
					if (i_q == '0) pre_q <= '0;
					else begin
						idx_q <= i_q - CW'(1);
						cur_q <= prev_q;
					end
				end
				ST_K_RD: if (idx_q == '0) pre_q <= CW'(1);
				ST_K_LD: begin
					nxt_q <= rdata_q;
					tp_q <= p_q; tq_q <= cur_q; tr_q <= rdata_q; wt_q <= 2'd2;
				end
				ST_K_WAIT: begin
					if (wt_q != '0) wt_q <= wt_q - 2'd1;
					else if (!lt) begin
						cur_q <= nxt_q;
						idx_q <= idx_q - CW'(1);
					end else begin
						pre_q <= idx_q + CW'(1);
					end
				end
				ST_PLAN_END: begin
					add_q  <= 1'b1;
					newn_q <= pre_q + CW'(1) + (n_q - j_q);
				end
				ST_MV_INIT: begin
					// shift the kept tail so it starts right after the new vertex
					asc_q <= (pre_q + CW'(1)) < j_q;
					if ((pre_q + CW'(1)) < j_q) begin
						src_q <= j_q;
						dst_q <= pre_q + CW'(1);
					end else begin
						src_q <= n_q - CW'(1);
						dst_q <= n_q;
					end
					rem_q <= ((pre_q + CW'(1)) == j_q) ? '0 : n_q - j_q;
				end
				ST_MV_WR: begin
					rem_q <= rem_q - CW'(1);
					if (asc_q) begin
						src_q <= src_q + CW'(1);
						dst_q <= dst_q + CW'(1);
					end else begin
						src_q <= src_q - CW'(1);
						dst_q <= dst_q - CW'(1);
					end
				end
				ST_PUT: n_q <= newn_q;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_fits: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(HULL_DEPTH))
		else $error("store count above depth");
	a_put_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUT |-> newn_q <= CW'(HULL_DEPTH))
		else $error("store written past depth");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == ST_IDLE)
		else $error("store started while busy");
`endif

endmodule

// ----- rtl/core/dynamic_convex_hull_core.sv -----
// Dynamic convex hull: upper hull and negated lower hull in two sorted vertex memories.
// A query scans each store up to the point's rank; an insert also walks over each erased
// neighbour and then shifts the kept tail one entry at a time through each store memory.
// Throughput: one item at a time; the next transfer is taken once the result sits in the
// output register. Reset (arst_n low) empties both stores at once; no clearing pass.
module dynamic_convex_hull_core import dch_pkg::*; #(
	parameter int HULL_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic signed [30:0] px,
	input  logic signed [30:0] py,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         position,
	output logic [8:0]         vertex_count,
	output logic               store_full
);

	localparam int CW = $clog2(HULL_DEPTH + 2);

	top_st_t state_q, state_d;
	store_ctl_t ctl;
	store_sts_t sts_u, sts_l;
	logic [CW-1:0] cnt_u, cnt_l, newn_u, newn_l;
	vtx_t pt_u, pt_l;
	logic kind_q, full_q, full_w, idle_both;
	logic [1:0] pos_q, pos_w;
	logic [CW:0] total;
	logic [CW:0] verts;

	// The lower hull is kept as an upper hull of the negated points.
	assign pt_u.x = {px[30], px};
	assign pt_u.y = {py[30], py};
	assign pt_l.x = 32'sd0 - {px[30], px};
	assign pt_l.y = 32'sd0 - {py[30], py};

	dch_store #(.HULL_DEPTH(HULL_DEPTH)) u_upper (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .pt(pt_u),
		.sts(sts_u), .count(cnt_u), .newn(newn_u)
	);

	dch_store #(.HULL_DEPTH(HULL_DEPTH)) u_lower (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .pt(pt_l),
		.sts(sts_l), .count(cnt_l), .newn(newn_l)
	);

	assign idle_both = !sts_u.busy && !sts_l.busy;

	// Refuse the insert when either planned store would overflow.
	assign full_w = (newn_u > CW'(HULL_DEPTH)) || (newn_l > CW'(HULL_DEPTH));

	// A point is in the hull only when both stores see it on or under; border wins.
	always_comb begin
		pos_w = SIDE_ABOVE;
		if (sts_u.side != SIDE_ABOVE && sts_l.side != SIDE_ABOVE)
			pos_w = (sts_u.side > sts_l.side) ? sts_u.side : sts_l.side;
	end

	assign total = {1'b0, cnt_u} + {1'b0, cnt_l};
	assign verts = (total <= (CW+1)'(2)) ? (total >> 1) : total - (CW+1)'(2);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE:  if (in_valid) state_d = T_RUN;
			T_RUN:   if (idle_both)
				state_d = (kind_q == KIND_INSERT && !full_w) ? T_APPLY : T_OUT;
			T_APPLY: if (idle_both) state_d = T_OUT;
			T_OUT:   if (!out_valid || !out_stall) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	// store commands and input stall
	always_comb begin
		in_stall  = state_q != T_IDLE;
		ctl.start = 1'b0;
		ctl.op    = OP_APPLY;
		unique case (state_q)
			T_IDLE: begin
				ctl.start = in_valid;
				ctl.op    = (kind == KIND_QUERY) ? OP_QUERY : OP_PLAN;
			end
			T_RUN:   ctl.start = idle_both && kind_q == KIND_INSERT && !full_w;
			default: ctl.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			// raise the result when it is loaded; drop it once its transfer completes
			if (state_q == T_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				T_IDLE: if (in_valid) kind_q <= kind;
				T_RUN: if (idle_both) begin
					full_q <= kind_q == KIND_INSERT && full_w;
					pos_q  <= (kind_q == KIND_QUERY) ? pos_w : SIDE_ABOVE;
				end
				T_OUT: if (!out_valid || !out_stall) begin
					position     <= pos_q;
					store_full   <= full_q;
					vertex_count <= 9'(verts);
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- tb/dch_checker.sv -----
`timescale 1ns / 100ps

module dch_checker import dch_pkg::*; #(
	parameter int HULL_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic signed [30:0] px,
	input  logic signed [30:0] py,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         position,
	input  logic [8:0]         vertex_count,
	input  logic               store_full,
	output int                 errors,
	output int                 backlog,
	output int                 n_full,
	output int                 n_inside,
	output int                 n_border
);

	typedef struct {
		logic [1:0] position;
		logic [8:0] vertex_count;
		logic       store_full;
	} hull_result_t;

	// store 0: upper hull, store 1: lower hull as negated points
	longint      hull_x [2][HULL_DEPTH];
	longint      hull_y [2][HULL_DEPTH];
	int          hull_n [2];
	hull_result_t results_due [$];

	function automatic bit turns_left(longint ax, longint ay, longint bx, longint by,
		longint cx, longint cy);
		return (bx - ax) * (cy - by) > (by - ay) * (cx - bx);
	endfunction

	function automatic bit sorts_first(longint ax, longint ay, longint bx, longint by);
		return (ax != bx) ? (ax < bx) : (ay < by);
	endfunction

	function automatic int rank_of(int s, longint x, longint y);
		int i;
		i = 0;
		while (i < hull_n[s] && sorts_first(hull_x[s][i], hull_y[s][i], x, y)) i++;
		return i;
	endfunction

	function automatic logic [1:0] side_of(int s, longint x, longint y);
		int i;
		i = rank_of(s, x, y);
		if (i >= hull_n[s]) return SIDE_ABOVE;
		if (i == 0) return (hull_x[s][0] == x && hull_y[s][0] == y) ? SIDE_ON : SIDE_ABOVE;
		if (turns_left(x, y, hull_x[s][i], hull_y[s][i], hull_x[s][i-1], hull_y[s][i-1]))
			return SIDE_UNDER;
		if (turns_left(x, y, hull_x[s][i-1], hull_y[s][i-1], hull_x[s][i], hull_y[s][i]))
			return SIDE_ABOVE;
		return SIDE_ON;
	endfunction

	// work out where the point goes and which neighbours drop out
	function automatic void splice_plan(int s, longint x, longint y, output bit add,
		output int pre, output int sfx, output int newn);
		int i, j, k;
		add = 0; pre = 0; sfx = 0; newn = hull_n[s];
		if (side_of(s, x, y) != SIDE_ABOVE) return;
		i = rank_of(s, x, y);
		j = i;
		if (i < hull_n[s])
			while (j + 1 < hull_n[s] &&
				!turns_left(hull_x[s][j+1], hull_y[s][j+1], hull_x[s][j], hull_y[s][j], x, y))
				j++;
		if (i != 0) begin
			k = i - 1;
			while (k > 0 &&
				!turns_left(x, y, hull_x[s][k], hull_y[s][k], hull_x[s][k-1], hull_y[s][k-1]))
				k--;
			pre = k + 1;
		end
		add = 1;
		sfx = j;
		newn = pre + 1 + (hull_n[s] - j);
	endfunction

	function automatic void splice_apply(int s, longint x, longint y, bit add, int pre,
		int sfx, int newn);
		longint tx [$];
		longint ty [$];
		if (!add) return;
		for (int m = sfx; m < hull_n[s]; m++) begin
			tx.push_back(hull_x[s][m]);
			ty.push_back(hull_y[s][m]);
		end
		hull_x[s][pre] = x;
		hull_y[s][pre] = y;
		foreach (tx[m]) begin
			hull_x[s][pre+1+m] = tx[m];
			hull_y[s][pre+1+m] = ty[m];
		end
		hull_n[s] = newn;
	endfunction

	function automatic hull_result_t hull_step(logic k, longint x, longint y);
		hull_result_t r;
		bit         add_u, add_l;
		int         pre_u, sfx_u, newn_u, pre_l, sfx_l, newn_l, total;
		logic [1:0] su, sl;
		r.position = SIDE_ABOVE;
		r.store_full = 0;
		if (k == KIND_INSERT) begin
			splice_plan(0, x, y, add_u, pre_u, sfx_u, newn_u);
			splice_plan(1, -x, -y, add_l, pre_l, sfx_l, newn_l);
			if (newn_u > HULL_DEPTH || newn_l > HULL_DEPTH) begin
				r.store_full = 1;
			end else begin
				splice_apply(0, x, y, add_u, pre_u, sfx_u, newn_u);
				splice_apply(1, -x, -y, add_l, pre_l, sfx_l, newn_l);
			end
		end else begin
			su = side_of(0, x, y);
			sl = side_of(1, -x, -y);
			if (su != SIDE_ABOVE && sl != SIDE_ABOVE) r.position = (su > sl) ? su : sl;
		end
		total = hull_n[0] + hull_n[1];
		r.vertex_count = 9'(total <= 2 ? total / 2 : total - 2);
		return r;
	endfunction

	hull_result_t got, want;
	int           bad;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hull_n[0] = 0;
			hull_n[1] = 0;
			results_due.delete();
			errors    <= 0;
			backlog   <= 0;
			n_full    <= 0;
			n_inside  <= 0;
			n_border  <= 0;
		end else begin
			bad = 0;
			// predict on every input transfer
			if (in_valid && !in_stall)
				results_due.push_back(hull_step(kind, longint'(px), longint'(py)));
			// compare every output transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				got.position     = position;
				got.vertex_count = vertex_count;
				got.store_full   = store_full;
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result pos=%0d count=%0d full=%0d", $time,
						got.position, got.vertex_count, got.store_full);
					bad++;
				end else begin
					want = results_due.pop_front();
					if (got.position == SIDE_UNDER) n_inside <= n_inside + 1;
					if (got.position == SIDE_ON) n_border <= n_border + 1;
					if (got.store_full) n_full <= n_full + 1;
					if (got.position !== want.position) begin
						$display("%0t: position expected %0d got %0d", $time,
							want.position, got.position);
						bad++;
					end
					if (got.vertex_count !== want.vertex_count) begin
						$display("%0t: vertex_count expected %0d got %0d", $time,
							want.vertex_count, got.vertex_count);
						bad++;
					end
					if (got.store_full !== want.store_full) begin
						$display("%0t: store_full expected %0d got %0d", $time,
							want.store_full, got.store_full);
						bad++;
					end
				end
			end
			errors  <= errors + bad;
			backlog <= results_due.size();
		end
	end

endmodule

// ----- tb/dynamic_convex_hull_core_tb.sv -----
`timescale 1ns / 100ps

module dynamic_convex_hull_core_tb import dch_pkg::*; ();

	localparam int HULL_DEPTH = 256;
	localparam int MIN31      = -(1 << 30);
	localparam int MAX31      = (1 << 30) - 1;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic signed [30:0] px;
	logic signed [30:0] py;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         position;
	logic [8:0]         vertex_count;
	logic               store_full;
	int                 errors, backlog, n_full, n_inside, n_border;
	int                 n_sent;

	// points already inserted; queried again to land on the border
	int placed_x [$];
	int placed_y [$];

	dynamic_convex_hull_core #(.HULL_DEPTH(HULL_DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .px(px), .py(py),
		.out_valid(out_valid), .out_stall(out_stall),
		.position(position), .vertex_count(vertex_count), .store_full(store_full)
	);

	dch_checker #(.HULL_DEPTH(HULL_DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .px(px), .py(py),
		.out_valid(out_valid), .out_stall(out_stall),
		.position(position), .vertex_count(vertex_count), .store_full(store_full),
		.errors(errors), .backlog(backlog),
		.n_full(n_full), .n_inside(n_inside), .n_border(n_border)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// hard stop for a hung block
	initial begin
		#40_000_000;
		$display("dynamic_convex_hull_core_tb failed");
		$finish;
	end

	// Offer one transfer and hold it until taken; idle afterwards at random.
	// Valid is lowered only when a gap follows, so it never toggles within a step.
	task automatic offer_point(logic k, int x, int y);
		int r;
		in_valid <= 1;
		kind     <= k;
		px       <= 31'(x);
		py       <= 31'(y);
		do @(posedge clk); while (in_stall);
		n_sent++;
		if (k == KIND_INSERT) begin
			placed_x.push_back(x);
			placed_y.push_back(y);
		end
		r = $urandom_range(99);
		if (r >= 65) begin
			in_valid <= 0;
			repeat (r >= 96 ? $urandom_range(60, 20) : $urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	// receiver: short random stalls, a few long ones, and one long hold-off
	// early on so the block backs up against the sender
	initial begin
		int r;
		int cycles;
		out_stall = 0;
		@(posedge arst_n);
		cycles = 0;
		forever begin
			r = $urandom_range(99);
			if (cycles > 600 && cycles < 1200) begin
				out_stall <= 1;
				repeat (3000) @(posedge clk);
				cycles = 1200;
			end else if (r < 60) begin
				out_stall <= 0;
				repeat ($urandom_range(8, 1)) @(posedge clk);
			end else if (r < 96) begin
				out_stall <= 1;
				repeat ($urandom_range(3, 1)) @(posedge clk);
			end else begin
				out_stall <= 1;
				repeat ($urandom_range(80, 20)) @(posedge clk);
			end
			cycles += 8;
		end
	end

	initial begin
		int r, span, pick, wait_cnt;
		in_valid = 0;
		kind     = KIND_INSERT;
		px       = 0;
		py       = 0;
		n_sent   = 0;
		arst_n   = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty hull, duplicates, covered and collinear points, extremes
		offer_point(KIND_QUERY, 0, 0);
		offer_point(KIND_QUERY, MIN31, MAX31);
		offer_point(KIND_INSERT, 0, 0);
		offer_point(KIND_QUERY, 0, 0);
		offer_point(KIND_INSERT, 0, 0);
		offer_point(KIND_INSERT, 10, 0);
		offer_point(KIND_QUERY, 5, 0);
		offer_point(KIND_INSERT, 5, 5);
		offer_point(KIND_INSERT, 5, -5);
		offer_point(KIND_INSERT, 5, 0);
		offer_point(KIND_INSERT, 2, 2);
		offer_point(KIND_QUERY, 5, 0);
		offer_point(KIND_QUERY, 1, 1);
		offer_point(KIND_QUERY, 5, 5);
		offer_point(KIND_QUERY, 20, 0);
		offer_point(KIND_QUERY, MIN31, MIN31);
		offer_point(KIND_QUERY, MAX31, MAX31);
		offer_point(KIND_QUERY, -1, 0);

		// random: a hull that grows slowly, with queries near and on it
		for (int n = 0; n < 1500; n++) begin
			span = (n < 300) ? 8 : (n < 900 ? 200 : 1 << 20);
			r = $urandom_range(99);
			if (r < 55) begin
				offer_point(KIND_INSERT, $urandom_range(2 * span) - span,
					$urandom_range(2 * span) - span);
			end else if (r < 75) begin
				pick = $urandom_range(placed_x.size() - 1);
				offer_point(KIND_QUERY, placed_x[pick], placed_y[pick]);
			end else if (r < 92) begin
				offer_point(KIND_QUERY, $urandom_range(2 * span) - span,
					$urandom_range(2 * span) - span);
			end else begin
				offer_point(KIND_QUERY, $signed(31'($urandom)), $signed(31'($urandom)));
			end
		end

		// overflow: a wide parabola above everything fills the upper store
		for (int i = 0; i < 300; i++) begin
			offer_point(KIND_INSERT, -(1 << 29) + i * (1 << 21),
				(1 << 29) - (i - 150) * (i - 150) * 8192);
			if (i % 10 == 0)
				offer_point(KIND_QUERY, $urandom_range(2000) - 1000,
					$urandom_range(2000) - 1000);
		end

		// extreme corners last, then probe the resulting box
		offer_point(KIND_INSERT, MIN31, MIN31);
		offer_point(KIND_INSERT, MAX31, MAX31);
		offer_point(KIND_INSERT, MIN31, MAX31);
		offer_point(KIND_INSERT, MAX31, MIN31);
		offer_point(KIND_QUERY, MIN31, MIN31);
		offer_point(KIND_QUERY, MIN31, 0);
		offer_point(KIND_QUERY, 0, 0);
		offer_point(KIND_QUERY, MAX31, MAX31);
		in_valid <= 0;

		// drain, then allow a short tail for stray results
		wait_cnt = 0;
		do begin
			@(posedge clk);
			wait_cnt++;
		end while (backlog != 0 && wait_cnt < 400_000);
		repeat (64) @(posedge clk);

		$display("covered %0d items: %0d inside, %0d on border, %0d refused inserts",
			n_sent, n_inside, n_border, n_full);
		$display("final vertex count %0d, results still owed %0d", vertex_count, backlog);
		if (errors == 0 && backlog == 0) begin
			$display("dynamic_convex_hull_core_tb passed");
		end else begin
			$display("dynamic_convex_hull_core_tb failed");
		end
		$finish;
	end

endmodule
